// ===== hdl/wbft_pkg.sv =====
// ----------------------------------------------------------------------------
// wbft_pkg
// Types and constants shared by the work/break/focus timer modules.
// ----------------------------------------------------------------------------
package wbft_pkg;

    localparam int unsigned SECS_PER_MIN = 60;
    localparam int unsigned BEEP_REMAIN  = 15;

    localparam int unsigned WORK_W  = 14;
    localparam int unsigned FOCUS_W = 15;
    localparam int unsigned WARN_W  = 12;
    localparam int unsigned CUT_W   = 12;
    localparam int unsigned SNZ_W   = 4;
    localparam int unsigned CFG_W   = 12;
    localparam int unsigned IDX_W   = 3;

    localparam logic [WORK_W-1:0]  WORK_MAX  = '1;
    localparam logic [FOCUS_W-1:0] FOCUS_MAX = '1;

    typedef enum logic [1:0] {
        RUN_WORK   = 2'd0,
        RUN_PAUSED = 2'd1,
        RUN_FOCUS  = 2'd2
    } t_run_state;

    typedef enum logic [2:0] {
        MD_TICK        = 3'd0,
        MD_START_WORK  = 3'd1,
        MD_START_FOCUS = 3'd2,
        MD_STOP_FOCUS  = 3'd3,
        MD_RESET       = 3'd4,
        MD_SNOOZE      = 3'd5,
        MD_LOCK        = 3'd6,
        MD_UNLOCK      = 3'd7
    } t_mode;

    typedef enum logic [IDX_W-1:0] {
        REG_WORK_MIN   = 3'd0,
        REG_FOCUS_MIN  = 3'd1,
        REG_WARN_SEC   = 3'd2,
        REG_SNOOZE_MIN = 3'd3,
        REG_MAX_SNOOZE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [WORK_W-1:0]  work_limit;
        logic [FOCUS_W-1:0] focus_limit;
        logic [WARN_W-1:0]  warn_secs;
        logic [CUT_W-1:0]   snooze_cut;
        logic [SNZ_W-1:0]   max_snoozes;
    } t_cfg;

    typedef struct packed {
        logic [2:0] mode;
        logic       user_idle;
        logic       lock_failed;
    } t_item;

    typedef struct packed {
        logic [1:0]         state_now;
        logic [WORK_W-1:0]  work_seconds;
        logic [FOCUS_W-1:0] focus_seconds;
        logic [SNZ_W-1:0]   snooze_count;
        logic               warned_flag;
        logic               idle_flag;
        logic               beep_pulse;
        logic               warn_pulse;
        logic               lock_request;
        logic               focus_done;
    } t_result;

endpackage

// ===== hdl/wbft_cfg.sv =====
// ----------------------------------------------------------------------------
// wbft_cfg
// Configuration registers; interval lengths are kept pre-scaled to seconds.
// ----------------------------------------------------------------------------
module wbft_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wbft_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [wbft_pkg::CFG_W-1:0]  i_cfg_data,
    output wbft_pkg::t_cfg              o_cfg
);
    import wbft_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.work_limit  <= WORK_W'(20 * SECS_PER_MIN);
            r_cfg.focus_limit <= FOCUS_W'(60 * SECS_PER_MIN);
            r_cfg.warn_secs   <= WARN_W'(60);
            r_cfg.snooze_cut  <= CUT_W'(5 * SECS_PER_MIN);
            r_cfg.max_snoozes <= SNZ_W'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WORK_MIN: begin
                    r_cfg.work_limit <= WORK_W'(i_cfg_data[7:0]) * WORK_W'(SECS_PER_MIN);
                end
                REG_FOCUS_MIN: begin
                    r_cfg.focus_limit <= FOCUS_W'(i_cfg_data[8:0]) * FOCUS_W'(SECS_PER_MIN);
                end
                REG_WARN_SEC: begin
                    r_cfg.warn_secs <= i_cfg_data[WARN_W-1:0];
                end
                REG_SNOOZE_MIN: begin
                    r_cfg.snooze_cut <= CUT_W'(i_cfg_data[5:0]) * CUT_W'(SECS_PER_MIN);
                end
                REG_MAX_SNOOZE: begin
                    r_cfg.max_snoozes <= i_cfg_data[SNZ_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/wbft_core.sv =====
// ----------------------------------------------------------------------------
// wbft_core
// Timer state, per-item update logic and the result register.
// ----------------------------------------------------------------------------
module wbft_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wbft_pkg::t_cfg    i_cfg,
    input  logic              i_item_valid,
    input  wbft_pkg::t_item   i_item,
    output logic              o_advance,
    output logic              o_res_valid,
    output wbft_pkg::t_result o_res,
    input  logic              i_res_ready
);
    import wbft_pkg::*;

    t_run_state         r_state, n_state;
    t_run_state         r_saved, n_saved;
    logic [WORK_W-1:0]  r_work,  n_work;
    logic [FOCUS_W-1:0] r_focus, n_focus;
    logic               r_warned, n_warned;
    logic [SNZ_W-1:0]   r_snz,   n_snz;
    logic               r_idle,  n_idle;
    logic               n_beep, n_warnp, n_lockr, n_fdone;
    logic [FOCUS_W-1:0] focus_inc;

    logic               r_res_valid;
    t_result            r_res;

    assign o_advance = i_item_valid && (!r_res_valid || i_res_ready);

    always_comb begin
        n_state   = r_state;
        n_saved   = r_saved;
        n_work    = r_work;
        n_focus   = r_focus;
        n_warned  = r_warned;
        n_snz     = r_snz;
        n_idle    = r_idle;
        n_beep    = 1'b0;
        n_warnp   = 1'b0;
        n_lockr   = 1'b0;
        n_fdone   = 1'b0;
        focus_inc = (r_focus != FOCUS_MAX) ? r_focus + 1'b1 : r_focus;
        unique case (t_mode'(i_item.mode))
            MD_TICK: begin
                if (r_state != RUN_PAUSED) begin
                    if (i_item.user_idle) begin
                        n_idle = 1'b1;
                    end else begin
                        n_idle = 1'b0;
                        if (r_state == RUN_FOCUS) begin
                            if (i_cfg.focus_limit <= focus_inc) begin
                                n_fdone = 1'b1;
                                n_state = RUN_WORK;
                                n_focus = '0;
                            end else begin
                                n_focus = focus_inc;
                            end
                        end else if (r_work != WORK_MAX) begin
                            n_work = r_work + 1'b1;
                        end
                        if (n_state == RUN_WORK) begin
                            n_beep = ({1'b0, n_work} + (WORK_W+1)'(BEEP_REMAIN))
                                     == {1'b0, i_cfg.work_limit};
                            if (!r_warned && ({1'b0, i_cfg.work_limit} <=
                                    {1'b0, n_work} + (WORK_W+1)'(i_cfg.warn_secs))) begin
                                n_warned = 1'b1;
                                n_warnp  = 1'b1;
                            end
                            if (i_cfg.work_limit <= n_work) begin
                                n_lockr = 1'b1;
                                n_saved = RUN_WORK;
                                n_state = RUN_PAUSED;
                                if (i_item.lock_failed) begin
                                    n_state  = RUN_WORK;
                                    n_focus  = '0;
                                    n_work   = '0;
                                    n_warned = 1'b0;
                                    n_snz    = '0;
                                end
                            end
                        end
                    end
                end
            end
            MD_START_WORK: begin
                n_state  = RUN_WORK;
                n_focus  = '0;
                n_work   = '0;
                n_warned = 1'b0;
                n_snz    = '0;
            end
            MD_START_FOCUS: begin
                n_state  = RUN_FOCUS;
                n_focus  = '0;
                n_warned = 1'b0;
            end
            MD_STOP_FOCUS: begin
                n_state = RUN_WORK;
                n_focus = '0;
            end
            MD_RESET: begin
                if (r_state == RUN_WORK) begin
                    n_work   = '0;
                    n_warned = 1'b0;
                    n_snz    = '0;
                end
            end
            MD_SNOOZE: begin
                if (r_state == RUN_WORK && r_snz < i_cfg.max_snoozes) begin
                    n_snz    = r_snz + 1'b1;
                    n_work   = (r_work > WORK_W'(i_cfg.snooze_cut))
                             ? r_work - WORK_W'(i_cfg.snooze_cut) : '0;
                    n_warned = 1'b0;
                end
            end
            MD_LOCK: begin
                if (r_state != RUN_PAUSED) begin
                    n_saved = r_state;
                    n_state = RUN_PAUSED;
                end else begin
                    n_saved = RUN_WORK;
                end
            end
            MD_UNLOCK: begin
                if (r_saved == RUN_FOCUS) begin
                    n_state = RUN_FOCUS;
                end else begin
                    n_state  = RUN_WORK;
                    n_work   = '0;
                    n_warned = 1'b0;
                    n_snz    = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= RUN_WORK;
            r_saved     <= RUN_WORK;
            r_work      <= '0;
            r_focus     <= '0;
            r_warned    <= 1'b0;
            r_snz       <= '0;
            r_idle      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_state     <= n_state;
                r_saved     <= n_saved;
                r_work      <= n_work;
                r_focus     <= n_focus;
                r_warned    <= n_warned;
                r_snz       <= n_snz;
                r_idle      <= n_idle;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_res.state_now     <= n_state;
            r_res.work_seconds  <= n_work;
            r_res.focus_seconds <= n_focus;
            r_res.snooze_count  <= n_snz;
            r_res.warned_flag   <= n_warned;
            r_res.idle_flag     <= n_idle;
            r_res.beep_pulse    <= n_beep;
            r_res.warn_pulse    <= n_warnp;
            r_res.lock_request  <= n_lockr;
            r_res.focus_done    <= n_fdone;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_lock_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.lock_request |->
            (r_res.state_now == RUN_PAUSED) ||
            (r_res.state_now == RUN_WORK && r_res.work_seconds == '0))
        else $error("lock request without pause or fresh work cycle");

    a_focus_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid && r_res.focus_done |->
            r_res.state_now != RUN_FOCUS && r_res.focus_seconds == '0)
        else $error("focus end left focus state or time behind");

    a_beep_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_res.beep_pulse && r_res.lock_request))
        else $error("beep and lock request on one tick");

    a_paused_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance && i_item.mode == MD_TICK && r_state == RUN_PAUSED |=>
            r_state == RUN_PAUSED && $stable(r_work) && $stable(r_idle))
        else $error("tick changed a paused timer");

endmodule

// ===== hdl/work_break_focus_timer.sv =====
// ----------------------------------------------------------------------------
// work_break_focus_timer
// Work / paused / focus interval timer driven by ticks and control events.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     i_in_valid/o_in_ready   i_mode, i_user_idle, i_lock_failed
//  output    o_out_valid/i_out_ready o_state_now .. o_focus_done
//  config    i_cfg_we                i_cfg_idx, i_cfg_data
//
//  One item per cycle sustained unless the output stalls; the state update
//  is combinational between the input register and the result register.
//  Synchronous active-low reset clears the timer state and loads register
//  defaults. A stalled result holds its register; the input register still
//  takes a transfer while the result waits, then stalls until it moves.
// ----------------------------------------------------------------------------
module work_break_focus_timer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wbft_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [wbft_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [2:0]                  i_mode,
    input  logic                        i_user_idle,
    input  logic                        i_lock_failed,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_state_now,
    output logic [wbft_pkg::WORK_W-1:0] o_work_seconds,
    output logic [wbft_pkg::FOCUS_W-1:0] o_focus_seconds,
    output logic [wbft_pkg::SNZ_W-1:0]  o_snooze_count,
    output logic                        o_warned_flag,
    output logic                        o_idle_flag,
    output logic                        o_beep_pulse,
    output logic                        o_warn_pulse,
    output logic                        o_lock_request,
    output logic                        o_focus_done
);
    import wbft_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_item_valid;
    logic    advance;
    t_result res;

    wbft_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_in_ready = !r_item_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_item_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.mode        <= i_mode;
            r_item.user_idle   <= i_user_idle;
            r_item.lock_failed <= i_lock_failed;
        end
    end

    wbft_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (r_item_valid),
        .i_item       (r_item),
        .o_advance    (advance),
        .o_res_valid  (o_out_valid),
        .o_res        (res),
        .i_res_ready  (i_out_ready)
    );

    assign o_state_now     = res.state_now;
    assign o_work_seconds  = res.work_seconds;
    assign o_focus_seconds = res.focus_seconds;
    assign o_snooze_count  = res.snooze_count;
    assign o_warned_flag   = res.warned_flag;
    assign o_idle_flag     = res.idle_flag;
    assign o_beep_pulse    = res.beep_pulse;
    assign o_warn_pulse    = res.warn_pulse;
    assign o_lock_request  = res.lock_request;
    assign o_focus_done    = res.focus_done;

endmodule
